[hw/rtl/wsa_pkg.sv]
// Shared types, constants and helper functions for the windowed slouch alert.
// Used by the front end, the queue, the back end and the top level.
package wsa_pkg;

    // Window geometry
    localparam int WIN_MAX   = 64;
    localparam int WIN_IDX_W = $clog2(WIN_MAX);
    localparam int CNT_W     = $clog2(WIN_MAX + 1);
    localparam int WIN_MIN   = 3;

    // Queue between front and back end
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Command codes on the input tuser
    localparam logic [2:0] CMD_SAMPLE  = 3'd0;
    localparam logic [2:0] CMD_TICK    = 3'd1;
    localparam logic [2:0] CMD_MODE    = 3'd2;
    localparam logic [2:0] CMD_LINK    = 3'd3;
    localparam logic [2:0] CMD_SESSION = 3'd4;

    // Mode codes
    localparam logic [1:0] MODE_DESK  = 2'd0;
    localparam logic [1:0] MODE_BREAK = 2'd1;

    // Configuration register indexes
    localparam logic [1:0] CFG_TILT_LIMIT      = 2'd0;
    localparam logic [1:0] CFG_RATIO_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_WINDOW_LENGTH   = 2'd2;
    localparam logic [1:0] CFG_COOLDOWN_MS     = 2'd3;

    // Reset values of the configuration registers
    localparam logic signed [15:0] RST_TILT_LIMIT      = 16'sd2000;
    localparam logic [8:0]         RST_RATIO_THRESHOLD = 9'd179;
    localparam logic [6:0]         RST_WINDOW_LENGTH   = 7'd30;
    localparam logic [31:0]        RST_COOLDOWN_MS     = 32'd60000;

    typedef enum logic [2:0] {
        OP_SAMPLE,
        OP_TICK,
        OP_MODE,
        OP_LINK,
        OP_SESSION,
        OP_NONE
    } op_kind_t;

    // Classified item handed from front end to back end
    typedef struct packed {
        op_kind_t    kind;
        logic        slouch_bit;
        logic [31:0] time_ms;
        logic [1:0]  mode_code;
        logic        link_up;
    } wsa_op_t;

    // Configuration seen by the back end
    typedef struct packed {
        logic [8:0]       ratio_threshold;
        logic [31:0]      cooldown_ms;
        logic [CNT_W-1:0] win_cap;
        logic [CNT_W-1:0] win_ready;
    } wsa_cfg_t;

    // Clamp the programmed length to [WIN_MIN, WIN_MAX]
    function automatic logic [CNT_W-1:0] win_cap_of(input logic [6:0] len);
        logic [CNT_W-1:0] c;
        if (int'(len) < WIN_MIN) begin
            c = CNT_W'(WIN_MIN);
        end else if (int'(len) > WIN_MAX) begin
            c = CNT_W'(WIN_MAX);
        end else begin
            c = CNT_W'(len);
        end
        return c;
    endfunction

    // max(WIN_MIN, cap / 3); cap / 3 as a multiply by 171/512
    function automatic logic [CNT_W-1:0] win_ready_of(input logic [CNT_W-1:0] cap);
        logic [CNT_W+7:0] prod;
        logic [CNT_W-1:0] third;
        prod  = (CNT_W + 8)'(cap) * (CNT_W + 8)'(171);
        third = CNT_W'(prod[CNT_W+7:9]);
        return (int'(third) < WIN_MIN) ? CNT_W'(WIN_MIN) : third;
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

[hw/rtl/windowed_slouch_alert.sv]
// Windowed slouch alert: a beat goes through the front end into the queue register,
// then through the back end into the output register that holds its result beat.
// Throughput one item per cycle while m_tready keeps the output register drained.
// rst_n clears all control and counter state at once, with no clearing pass (payload
// is not reset); the block takes items as soon as reset is released.
// Depends on wsa_pkg, wsa_front, wsa_queue and wsa_back.
module windowed_slouch_alert (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_data,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] angle_centideg, [47:16] time_ms, [49:48] mode_code, [50] link_up
    input  logic [55:0]  s_tdata,
    // [2:0] command
    input  logic [2:0]   s_tuser,
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] alert_armed, [1] buzz_now, [2] slouching, [9:3] window_ones,
    // [16:10] window_fill, [32:17] alert_count, [64:33] good_time_ms,
    // [96:65] total_time_ms
    output logic [103:0] m_tdata
);
    import wsa_pkg::*;

    // Configuration registers. The window length is kept in its clamped form
    // together with the fill level at which the ratio test starts.
    logic signed [15:0] tilt_limit_reg, tilt_limit_next;
    logic [8:0]         threshold_reg, threshold_next;
    logic [31:0]        cooldown_reg, cooldown_next;
    logic [CNT_W-1:0]   win_cap_reg, win_cap_next;
    logic [CNT_W-1:0]   win_ready_reg, win_ready_next;
    logic               win_clr;

    wsa_cfg_t           cfg;

    // Front end to queue
    logic               q_full;
    logic               q_push;
    wsa_op_t            push_op;

    // Queue to back end
    logic               q_valid;
    logic               q_pop;
    wsa_op_t            head_op;

    // A write to the window length restarts the window
    assign win_clr = cfg_we && (cfg_addr == CFG_WINDOW_LENGTH);

    always_comb
    begin
        tilt_limit_next = tilt_limit_reg;
        threshold_next  = threshold_reg;
        cooldown_next   = cooldown_reg;
        win_cap_next    = win_cap_reg;
        win_ready_next  = win_ready_reg;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_TILT_LIMIT:      tilt_limit_next = cfg_data[15:0];
                CFG_RATIO_THRESHOLD: threshold_next  = cfg_data[8:0];
                CFG_WINDOW_LENGTH:
                begin
                    win_cap_next   = win_cap_of(cfg_data[6:0]);
                    win_ready_next = win_ready_of(win_cap_of(cfg_data[6:0]));
                end
                CFG_COOLDOWN_MS:     cooldown_next   = cfg_data;
                default:
                begin
                    // no such register
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tilt_limit_reg <= RST_TILT_LIMIT;
            threshold_reg  <= RST_RATIO_THRESHOLD;
            cooldown_reg   <= RST_COOLDOWN_MS;
            win_cap_reg    <= win_cap_of(RST_WINDOW_LENGTH);
            win_ready_reg  <= win_ready_of(win_cap_of(RST_WINDOW_LENGTH));
        end else begin
            tilt_limit_reg <= tilt_limit_next;
            threshold_reg  <= threshold_next;
            cooldown_reg   <= cooldown_next;
            win_cap_reg    <= win_cap_next;
            win_ready_reg  <= win_ready_next;
        end
    end

    assign cfg.ratio_threshold = threshold_reg;
    assign cfg.cooldown_ms     = cooldown_reg;
    assign cfg.win_cap         = win_cap_reg;
    assign cfg.win_ready       = win_ready_reg;

    // Classify beats and turn the angle into a slouch bit
    wsa_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .tilt_limit (tilt_limit_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_op       (push_op)
    );

    // Decouple the input side from result back-pressure
    wsa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .head_op (head_op)
    );

    // Apply each item to the window and counters, register the result beat
    wsa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .win_clr  (win_clr),
        .q_valid  (q_valid),
        .q_op     (head_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[hw/rtl/wsa_front.sv]
// Front end of the windowed slouch alert: takes input beats and classifies them.
// Depends on wsa_pkg.
module wsa_front (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [55:0]           s_tdata,
    input  logic [2:0]            s_tuser,
    input  logic signed [15:0]    tilt_limit,
    input  logic                  q_full,
    output logic                  q_push,
    output wsa_pkg::wsa_op_t      q_op
);
    import wsa_pkg::*;

    logic signed [15:0] angle;

    assign angle    = s_tdata[15:0];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_op.slouch_bit = (angle > tilt_limit);
        q_op.time_ms    = s_tdata[47:16];
        q_op.mode_code  = s_tdata[49:48];
        q_op.link_up    = s_tdata[50];
        case (s_tuser)
            CMD_SAMPLE:  q_op.kind = OP_SAMPLE;
            CMD_TICK:    q_op.kind = OP_TICK;
            CMD_MODE:    q_op.kind = OP_MODE;
            CMD_LINK:    q_op.kind = OP_LINK;
            CMD_SESSION: q_op.kind = OP_SESSION;
            default:     q_op.kind = OP_NONE;
        endcase
    end

endmodule

[hw/rtl/wsa_queue.sv]
// Short queue of classified items between front and back end.
// Depends on wsa_pkg.
module wsa_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wsa_pkg::wsa_op_t  push_op,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output wsa_pkg::wsa_op_t  head_op
);
    import wsa_pkg::*;

    wsa_op_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign full    = (int'(count_reg) == Q_DEPTH);
    assign valid   = (count_reg != '0);
    assign head_op = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == Q_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == Q_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

[hw/rtl/wsa_back.sv]
// Back end of the windowed slouch alert: window, buzz logic, session counters
// and the output register. Depends on wsa_pkg.
module wsa_back (
    input  logic              clk,
    input  logic              rst_n,
    input  wsa_pkg::wsa_cfg_t cfg,
    input  logic              win_clr,
    input  logic              q_valid,
    input  wsa_pkg::wsa_op_t  q_op,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [103:0]      m_tdata
);
    import wsa_pkg::*;

    // Window and decision state
    logic [WIN_MAX-1:0] win_reg, win_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   ones_reg, ones_next;
    logic               slouch_reg, slouch_next;
    logic               pending_reg, pending_next;
    logic [31:0]        last_buzz_reg, last_buzz_next;
    logic               seen_reg, seen_next;
    logic [31:0]        last_tick_reg, last_tick_next;
    logic               desk_reg, desk_next;
    logic               link_reg, link_next;
    logic [15:0]        alerts_reg, alerts_next;
    logic [31:0]        good_reg, good_next;
    logic [31:0]        total_reg, total_next;

    // Output stage
    logic               out_valid_reg, out_valid_next;
    logic [103:0]       out_data_reg, out_data_next;

    // Sample path
    logic               full_win;
    logic               evict;
    logic [CNT_W-1:0]   fill_push;
    logic [CNT_W-1:0]   ones_push;
    logic [CNT_W+8:0]   ones_scaled;
    logic [CNT_W+8:0]   thr_fill;
    logic [31:0]        since_buzz;
    logic [31:0]        dt;
    logic               armed;
    logic               buzz;

    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign full_win    = (fill_reg >= cfg.win_cap);
    assign evict       = full_win && win_reg[WIN_IDX_W'(cfg.win_cap - 1'b1)];
    assign fill_push   = full_win ? cfg.win_cap : fill_reg + 1'b1;
    assign ones_push   = ones_reg - CNT_W'(evict) + CNT_W'(q_op.slouch_bit);
    assign ones_scaled = {(CNT_W + 9)'(ones_push)} << 8;
    assign thr_fill    = (CNT_W + 9)'(cfg.ratio_threshold) * (CNT_W + 9)'(fill_push);
    assign since_buzz  = q_op.time_ms - last_buzz_reg;
    assign dt          = q_op.time_ms - last_tick_reg;

    always_comb
    begin
        win_next       = win_reg;
        fill_next      = fill_reg;
        ones_next      = ones_reg;
        slouch_next    = slouch_reg;
        pending_next   = pending_reg;
        last_buzz_next = last_buzz_reg;
        seen_next      = seen_reg;
        last_tick_next = last_tick_reg;
        desk_next      = desk_reg;
        link_next      = link_reg;
        alerts_next    = alerts_reg;
        good_next      = good_reg;
        total_next     = total_reg;
        armed          = 1'b0;
        buzz           = 1'b0;

        if (q_pop) begin
            case (q_op.kind)
                OP_SAMPLE:
                begin
                    win_next  = {win_reg[WIN_MAX-2:0], q_op.slouch_bit};
                    fill_next = fill_push;
                    ones_next = ones_push;
                    if (desk_reg && (fill_push >= cfg.win_ready)) begin
                        slouch_next = (ones_scaled >= thr_fill);
                        if (slouch_next && !pending_reg &&
                            (!seen_reg || (since_buzz >= cfg.cooldown_ms))) begin
                            pending_next = 1'b1;
                            armed        = 1'b1;
                            if (alerts_reg != 16'hFFFF) begin
                                alerts_next = alerts_reg + 16'd1;
                            end
                        end
                    end else begin
                        slouch_next = 1'b0;
                    end
                end
                OP_TICK:
                begin
                    last_tick_next = q_op.time_ms;
                    if (link_reg && desk_reg) begin
                        total_next = sat_add32(total_reg, dt);
                        if (!slouch_reg) begin
                            good_next = sat_add32(good_reg, dt);
                        end
                    end
                    if (pending_reg) begin
                        buzz           = 1'b1;
                        pending_next   = 1'b0;
                        last_buzz_next = q_op.time_ms;
                        seen_next      = 1'b1;
                    end
                end
                OP_MODE:
                begin
                    desk_next = (q_op.mode_code == MODE_DESK);
                    if (q_op.mode_code == MODE_BREAK) begin
                        win_next    = '0;
                        fill_next   = '0;
                        ones_next   = '0;
                        slouch_next = 1'b0;
                    end
                end
                OP_LINK:
                begin
                    link_next = q_op.link_up;
                    if (!q_op.link_up) begin
                        win_next    = '0;
                        fill_next   = '0;
                        ones_next   = '0;
                        slouch_next = 1'b0;
                    end
                end
                OP_SESSION:
                begin
                    alerts_next    = '0;
                    good_next      = '0;
                    total_next     = '0;
                    win_next       = '0;
                    fill_next      = '0;
                    ones_next      = '0;
                    last_buzz_next = '0;
                    seen_next      = 1'b0;
                end
                default:
                begin
                    // Unknown command: report status only
                end
            endcase
        end

        // Window length write: user must keep the block idle, not enforced
        if (win_clr) begin
            win_next  = '0;
            fill_next = '0;
            ones_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (q_pop) begin
            out_valid_next = 1'b1;
            out_data_next  = {7'd0, total_next, good_next, alerts_next,
                              7'(fill_next), 7'(ones_next), slouch_next, buzz, armed};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            win_reg       <= '0;
            fill_reg      <= '0;
            ones_reg      <= '0;
            slouch_reg    <= 1'b0;
            pending_reg   <= 1'b0;
            last_buzz_reg <= '0;
            seen_reg      <= 1'b0;
            last_tick_reg <= '0;
            desk_reg      <= 1'b1;
            link_reg      <= 1'b0;
            alerts_reg    <= '0;
            good_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            win_reg       <= win_next;
            fill_reg      <= fill_next;
            ones_reg      <= ones_next;
            slouch_reg    <= slouch_next;
            pending_reg   <= pending_next;
            last_buzz_reg <= last_buzz_next;
            seen_reg      <= seen_next;
            last_tick_reg <= last_tick_next;
            desk_reg      <= desk_next;
            link_reg      <= link_next;
            alerts_reg    <= alerts_next;
            good_reg      <= good_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule
